[rtl/sssb_pkg.sv]
// Shared types and constants for the sparse span sprite blitter.
// No dependencies; imported by every module of the block.
package sssb_pkg;

    localparam int WORD_W     = 16;
    localparam int ADDR_W     = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0]
    {
        PH_HDR_LO   = 3'd0,
        PH_HDR_HI   = 3'd1,
        PH_SPAN_X   = 3'd2,
        PH_SPAN_Y   = 3'd3,
        PH_SPAN_LEN = 3'd4,
        PH_PIXELS   = 3'd5
    } phase_t;

    typedef enum logic [2:0]
    {
        REG_SPRITE_X    = 3'd0,
        REG_SPRITE_Y    = 3'd1,
        REG_DEST_WIDTH  = 3'd2,
        REG_DEST_HEIGHT = 3'd3,
        REG_ROW_STRIDE  = 3'd4,
        REG_SKIP_NTH    = 3'd5
    } cfg_reg_t;

    // width and stride arrive already limited to the build maximums
    typedef struct packed
    {
        logic signed [15:0] sprite_x;
        logic signed [15:0] sprite_y;
        logic [12:0]        width;
        logic [12:0]        height;
        logic [13:0]        stride;
        logic [7:0]         skip_nth;
    } cfg_t;

    typedef struct packed
    {
        logic              emit;
        logic [ADDR_W-1:0] dest_addr;
        logic [WORD_W-1:0] pixel;
    } pix_t;

endpackage

[rtl/sssb_cfg_regs.sv]
// Configuration register file with width and stride limiting.
// Depends on sssb_pkg.
module sssb_cfg_regs #(
    parameter int MAX_DEST_WIDTH = 4096,
    parameter int MAX_STRIDE     = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sssb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sssb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output sssb_pkg::cfg_t                  cfg
);
    import sssb_pkg::*;

    logic signed [15:0] sprite_x_reg;
    logic signed [15:0] sprite_y_reg;
    logic [12:0]        dest_width_reg;
    logic [12:0]        dest_height_reg;
    logic [13:0]        row_stride_reg;
    logic [7:0]         skip_nth_reg;
    cfg_reg_t           idx;

    assign idx = cfg_reg_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_x_reg    <= '0;
            sprite_y_reg    <= '0;
            dest_width_reg  <= 13'd4096;
            dest_height_reg <= 13'd4096;
            row_stride_reg  <= 14'd4096;
            skip_nth_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (idx)
                REG_SPRITE_X:    sprite_x_reg    <= $signed(cfg_wdata[15:0]);
                REG_SPRITE_Y:    sprite_y_reg    <= $signed(cfg_wdata[15:0]);
                REG_DEST_WIDTH:  dest_width_reg  <= cfg_wdata[12:0];
                REG_DEST_HEIGHT: dest_height_reg <= cfg_wdata[12:0];
                REG_ROW_STRIDE:  row_stride_reg  <= cfg_wdata[13:0];
                REG_SKIP_NTH:    skip_nth_reg    <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cfg.sprite_x = sprite_x_reg;
        cfg.sprite_y = sprite_y_reg;
        cfg.height   = dest_height_reg;
        cfg.skip_nth = skip_nth_reg;
        cfg.width    = (32'(dest_width_reg) > MAX_DEST_WIDTH) ?
                       13'(MAX_DEST_WIDTH) : dest_width_reg;
        cfg.stride   = (32'(row_stride_reg) > MAX_STRIDE) ?
                       14'(MAX_STRIDE) : row_stride_reg;
    end

endmodule

[rtl/sssb_span_parser.sv]
// Stream parser: header count, span clipping, row dropping, pixel addressing.
// One word is consumed per advance. Depends on sssb_pkg.
module sssb_span_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic [sssb_pkg::WORD_W-1:0] word,
    input  logic                        frame_start,
    input  sssb_pkg::cfg_t              cfg,
    output sssb_pkg::pix_t              pix
);
    import sssb_pkg::*;

    phase_t             parse_phase_reg, parse_phase_next;
    logic [31:0]        words_left_reg, words_left_next;
    logic [16:0]        span_col_reg, span_col_next;
    logic [16:0]        span_row_reg, span_row_next;
    logic [15:0]        drop_lead_reg, drop_lead_next;
    logic [15:0]        copy_left_reg, copy_left_next;
    logic [15:0]        drop_tail_reg, drop_tail_next;
    logic [7:0]         line_phase_reg, line_phase_next;
    logic signed [16:0] last_row_reg, last_row_next;
    logic               stopped_reg, stopped_next;

    // state as seen after a frame start
    phase_t             phase_eff;
    logic               stopped_eff;
    logic signed [16:0] last_row_eff;
    logic [15:0]        dl_eff, cl_eff, dt_eff;

    logic [31:0]        hdr_count;
    logic [31:0]        wl_dec;

    logic signed [17:0] tl_row, tl_col;
    logic [17:0]        tl_neg_col;
    logic               tl_out_rows, tl_clip, tl_new_row, tl_draw;
    logic [15:0]        tl_lead, tl_n0, tl_n, tl_tail;
    logic [12:0]        tl_c, tl_room;
    logic [8:0]         lp_inc;
    logic [7:0]         lp_step, lp_new;

    logic [26:0]        pix_prod;

    assign phase_eff    = frame_start ? PH_HDR_LO : parse_phase_reg;
    assign stopped_eff  = frame_start ? 1'b0 : stopped_reg;
    assign last_row_eff = frame_start ? '1 : last_row_reg;
    assign dl_eff       = frame_start ? '0 : drop_lead_reg;
    assign cl_eff       = frame_start ? '0 : copy_left_reg;
    assign dt_eff       = frame_start ? '0 : drop_tail_reg;

    assign hdr_count = {word, words_left_reg[15:0]};
    assign wl_dec    = (words_left_reg != '0) ? words_left_reg - 32'd1 : words_left_reg;

    // span placement and clipping
    assign tl_row      = $signed({{2{cfg.sprite_y[15]}}, cfg.sprite_y})
                       + $signed({1'b0, span_row_reg});
    assign tl_col      = $signed({{2{cfg.sprite_x[15]}}, cfg.sprite_x})
                       + $signed({1'b0, span_col_reg});
    assign tl_neg_col  = 18'(-tl_col);
    assign tl_out_rows = tl_row >= $signed({5'b0, cfg.height});
    assign tl_clip     = tl_row[17]
                       || (tl_col >= $signed({5'b0, cfg.width}))
                       || (tl_col[17] && ({2'b0, word} <= tl_neg_col));
    assign tl_lead     = tl_col[17] ? tl_neg_col[15:0] : '0;
    assign tl_c        = tl_col[17] ? '0 : tl_col[12:0];
    assign tl_n0       = word - tl_lead;
    assign tl_room     = cfg.width - tl_c;
    assign tl_n        = (tl_n0 > {3'b0, tl_room}) ? {3'b0, tl_room} : tl_n0;
    assign tl_tail     = tl_n0 - tl_n;

    // row dropping
    assign tl_new_row = $signed({last_row_eff[16], last_row_eff}) != tl_row;
    assign lp_inc     = {1'b0, line_phase_reg} + 9'd1;
    assign lp_step    = (lp_inc >= {1'b0, cfg.skip_nth}) ? '0 : lp_inc[7:0];
    assign lp_new     = tl_new_row ? lp_step : line_phase_reg;
    assign tl_draw    = (cfg.skip_nth == '0) || (lp_new != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase_reg <= PH_HDR_LO;
            words_left_reg  <= '0;
            span_col_reg    <= '0;
            span_row_reg    <= '0;
            drop_lead_reg   <= '0;
            copy_left_reg   <= '0;
            drop_tail_reg   <= '0;
            line_phase_reg  <= '0;
            last_row_reg    <= '1;
            stopped_reg     <= 1'b0;
        end
        else
        begin
            parse_phase_reg <= parse_phase_next;
            words_left_reg  <= words_left_next;
            span_col_reg    <= span_col_next;
            span_row_reg    <= span_row_next;
            drop_lead_reg   <= drop_lead_next;
            copy_left_reg   <= copy_left_next;
            drop_tail_reg   <= drop_tail_next;
            line_phase_reg  <= line_phase_next;
            last_row_reg    <= last_row_next;
            stopped_reg     <= stopped_next;
        end
    end

    // next state
    always_comb
    begin
        parse_phase_next = parse_phase_reg;
        words_left_next  = words_left_reg;
        span_col_next    = span_col_reg;
        span_row_next    = span_row_reg;
        drop_lead_next   = drop_lead_reg;
        copy_left_next   = copy_left_reg;
        drop_tail_next   = drop_tail_reg;
        line_phase_next  = line_phase_reg;
        last_row_next    = last_row_reg;
        stopped_next     = stopped_reg;
        if (adv)
        begin
            parse_phase_next = phase_eff;
            stopped_next     = stopped_eff;
            last_row_next    = last_row_eff;
            drop_lead_next   = dl_eff;
            copy_left_next   = cl_eff;
            drop_tail_next   = dt_eff;
            if (!stopped_eff)
            begin
                case (phase_eff)
                    PH_HDR_LO:
                    begin
                        words_left_next  = {16'b0, word};
                        parse_phase_next = PH_HDR_HI;
                    end
                    PH_HDR_HI:
                    begin
                        if (hdr_count <= 32'd2)
                        begin
                            words_left_next = '0;
                            stopped_next    = 1'b1;
                        end
                        else
                        begin
                            words_left_next  = hdr_count - 32'd2;
                            parse_phase_next = PH_SPAN_X;
                        end
                    end
                    PH_SPAN_X:
                    begin
                        words_left_next  = wl_dec;
                        span_col_next    = {1'b0, word};
                        parse_phase_next = PH_SPAN_Y;
                    end
                    PH_SPAN_Y:
                    begin
                        words_left_next  = wl_dec;
                        span_row_next    = {1'b0, word};
                        parse_phase_next = PH_SPAN_LEN;
                    end
                    PH_SPAN_LEN:
                    begin
                        words_left_next = wl_dec;
                        drop_lead_next  = '0;
                        copy_left_next  = '0;
                        drop_tail_next  = '0;
                        if (tl_out_rows)
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            if (tl_clip)
                            begin
                                drop_lead_next = word;
                            end
                            else
                            begin
                                if (cfg.skip_nth != '0 && tl_new_row)
                                begin
                                    line_phase_next = lp_step;
                                    last_row_next   = tl_row[16:0];
                                end
                                if (tl_draw)
                                begin
                                    drop_lead_next = tl_lead;
                                    copy_left_next = tl_n;
                                    drop_tail_next = tl_tail;
                                    span_col_next  = {4'b0, tl_c};
                                    span_row_next  = tl_row[16:0];
                                end
                                else
                                begin
                                    drop_lead_next = word;
                                end
                            end
                            if (drop_lead_next == '0 && copy_left_next == '0
                                && drop_tail_next == '0)
                            begin
                                if (wl_dec == '0)
                                    stopped_next = 1'b1;
                                else
                                    parse_phase_next = PH_SPAN_X;
                            end
                            else
                            begin
                                parse_phase_next = PH_PIXELS;
                            end
                        end
                    end
                    PH_PIXELS:
                    begin
                        words_left_next = wl_dec;
                        if (dl_eff != '0)
                        begin
                            drop_lead_next = dl_eff - 16'd1;
                        end
                        else if (cl_eff != '0)
                        begin
                            copy_left_next = cl_eff - 16'd1;
                            span_col_next  = span_col_reg + 17'd1;
                        end
                        else if (dt_eff != '0)
                        begin
                            drop_tail_next = dt_eff - 16'd1;
                        end
                        if (drop_lead_next == '0 && copy_left_next == '0
                            && drop_tail_next == '0)
                        begin
                            if (wl_dec == '0)
                                stopped_next = 1'b1;
                            else
                                parse_phase_next = PH_SPAN_X;
                        end
                    end
                    default:
                    begin
                        words_left_next = wl_dec;
                        stopped_next    = 1'b1;
                    end
                endcase
            end
        end
    end

    // outputs
    assign pix_prod = 27'(span_row_reg[12:0]) * 27'(cfg.stride);

    always_comb
    begin
        pix.emit      = adv && !stopped_eff && (phase_eff == PH_PIXELS)
                        && (dl_eff == '0) && (cl_eff != '0);
        pix.dest_addr = ADDR_W'(pix_prod + 27'(span_col_reg));
        pix.pixel     = word;
    end

    a_pixels_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (parse_phase_reg == PH_PIXELS && !stopped_reg)
        |-> ((drop_lead_reg | copy_left_reg | drop_tail_reg) != '0))
        else $error("pixel phase with no words left in span");

    a_copy_count: assert property (@(posedge clk) disable iff (!rst_n)
        pix.emit |=> (copy_left_reg == $past(copy_left_reg) - 16'd1))
        else $error("copy count did not step on a pixel write");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        pix.emit |=> (span_col_reg == $past(span_col_reg) + 17'd1))
        else $error("column did not advance on a pixel write");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && frame_start) |=> (parse_phase_reg == PH_HDR_HI && !stopped_reg))
        else $error("frame start did not restart the header");

endmodule

[rtl/sparse_span_sprite_blitter_top.sv]
// Sparse span sprite blitter, top level: input word register, parser, result register.
// Depends on sssb_pkg, sssb_cfg_regs and sssb_span_parser.
//
// Takes one 16-bit stream word per clock, sustained; a word waits in the input register
// only while an unread pixel write holds the output register. A word is parsed from
// the input register in a single step; a pixel write, when the word gives one,
// appears in the output register on the next edge, so a word passes through the input
// register and then the output register on its way to m_tvalid. In front of the
// output register lie the parse update and the one row-times-stride multiply.
// No clearing pass after reset. Configuration writes take effect on the next clock.
module sparse_span_sprite_blitter_top #(
    parameter int MAX_DEST_WIDTH = 4096,
    parameter int MAX_STRIDE     = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] word
    input  logic                            s_tuser,   // [0] frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,   // [24:0] dest_addr, [40:25] pixel
    input  logic                            cfg_we,
    input  logic [sssb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sssb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sssb_pkg::*;

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_fs_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [WORD_W-1:0] out_pixel_reg;
    logic              adv;
    cfg_t              cfg;
    pix_t              pix;

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    sssb_cfg_regs #(
        .MAX_DEST_WIDTH (MAX_DEST_WIDTH),
        .MAX_STRIDE     (MAX_STRIDE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sssb_span_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .word        (in_word_reg),
        .frame_start (in_fs_reg),
        .cfg         (cfg),
        .pix         (pix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (adv)
                out_valid_reg <= pix.emit;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_word_reg <= s_tdata;
            in_fs_reg   <= s_tuser;
        end
        if (adv && pix.emit)
        begin
            out_addr_reg  <= pix.dest_addr;
            out_pixel_reg <= pix.pixel;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_pixel_reg, out_addr_reg};

endmodule
